// File: hw/rtl/xy_position_pid_with_reference_model_top_defines.svh
// assertion macros shared by the xy position controller
`ifndef XY_POSITION_PID_WITH_REFERENCE_MODEL_TOP_DEFINES_SVH
`define XY_POSITION_PID_WITH_REFERENCE_MODEL_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define XYPID_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("xypid check failed");

// condition must never be true outside reset
`define XYPID_NEVER(name, clk, rst_n, cond) \
  `XYPID_ASSERT(name, clk, rst_n, !(cond))

`else

`define XYPID_ASSERT(name, clk, rst_n, prop)
`define XYPID_NEVER(name, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/xypid_pkg.sv
package xypid_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned GainW    = 24;
  localparam int unsigned TsW      = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumAxes  = 2;
  // signed data times gain with a zero sign bit in front
  localparam int unsigned ProdW    = DataW + GainW + 1;
  // up to four data terms summed exactly
  localparam int unsigned SumW     = DataW + 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegRefKp    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRefKd    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPidKp    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPidKi    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPidKd    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTimeStep = 3'd5;

  // register reset values
  localparam logic [GainW-1:0] RefKpRst    = 24'd65536;
  localparam logic [GainW-1:0] RefKdRst    = 24'd65536;
  localparam logic [GainW-1:0] PidKpRst    = 24'd65536;
  localparam logic [GainW-1:0] PidKiRst    = 24'd0;
  localparam logic [GainW-1:0] PidKdRst    = 24'd0;
  localparam logic [TsW-1:0]   TimeStepRst = 16'd655;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EREF,
    ST_M1,
    ST_M2,
    ST_ACC,
    ST_M3,
    ST_VEL,
    ST_M4,
    ST_POS,
    ST_ERR,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_INT,
    ST_FIN
  } xypid_state_e;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_EREF_RKP,
    MUL_VEL_RKD,
    MUL_ACC_TS,
    MUL_VEL_TS,
    MUL_ERR_KI,
    MUL_ERR_KP,
    MUL_TMP_TS,
    MUL_DERR_KD
  } xypid_mul_e;

  typedef struct packed {
    logic       ld_in;
    logic       ld_eref;
    logic       mul_en;
    xypid_mul_e mul_sel;
    logic       ld_tmp;
    logic       ld_acc;
    logic       upd_vel;
    logic       upd_pos;
    logic       ld_err;
    logic       ld_sum;
    logic       upd_integ;
    logic       ld_res;
  } xypid_cmd_t;

  function automatic logic signed [SumW-1:0] ext_sum(input logic signed [DataW-1:0] v);
    return {{(SumW-DataW){v[DataW-1]}}, v};
  endfunction

  // clamp a wide sum to the signed data range
  function automatic logic signed [DataW-1:0] sat_data(input logic signed [SumW-1:0] v);
    logic [SumW-DataW:0] top;
    top = v[SumW-1:DataW-1];
    if ((&top) || !(|top)) begin
      return v[DataW-1:0];
    end else if (v[SumW-1]) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end else begin
      return {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

endpackage

// File: hw/rtl/xypid_dp.sv
module xypid_dp import xypid_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  xypid_cmd_t              cmd_i,
  input  logic        [GainW-1:0] ref_kp_i,
  input  logic        [GainW-1:0] ref_kd_i,
  input  logic        [GainW-1:0] pid_kp_i,
  input  logic        [GainW-1:0] pid_ki_i,
  input  logic        [GainW-1:0] pid_kd_i,
  input  logic        [TsW-1:0]   time_step_i,
  input  logic signed [DataW-1:0] cmd_x_i,
  input  logic signed [DataW-1:0] cmd_y_i,
  input  logic signed [DataW-1:0] meas_pos_x_i,
  input  logic signed [DataW-1:0] meas_pos_y_i,
  input  logic signed [DataW-1:0] meas_vel_x_i,
  input  logic signed [DataW-1:0] meas_vel_y_i,
  output logic signed [DataW-1:0] acc_out_x_o,
  output logic signed [DataW-1:0] acc_out_y_o
);

  localparam int unsigned ShW = ProdW - FRAC_BITS;
  localparam logic signed [ProdW-1:0] Half = ProdW'(1) <<< (FRAC_BITS - 1);

  // round half up, drop fraction bits, clamp to data range
  function automatic logic signed [DataW-1:0] fx_round(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] r;
    logic        [ShW-1:0]   s;
    logic        [ShW-DataW:0] top;
    r   = p + Half;
    s   = r[ProdW-1:FRAC_BITS];
    top = s[ShW-1:DataW-1];
    if ((&top) || !(|top)) begin
      return s[DataW-1:0];
    end else if (s[ShW-1]) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end else begin
      return {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

  logic signed [DataW-1:0] in_cmd   [NumAxes];
  logic signed [DataW-1:0] in_mpos  [NumAxes];
  logic signed [DataW-1:0] in_mvel  [NumAxes];

  logic signed [DataW-1:0] cmd_q    [NumAxes];
  logic signed [DataW-1:0] mpos_q   [NumAxes];
  logic signed [DataW-1:0] mvel_q   [NumAxes];
  logic signed [DataW-1:0] pos_q    [NumAxes];
  logic signed [DataW-1:0] vel_q    [NumAxes];
  logic signed [DataW-1:0] integ_q  [NumAxes];
  logic signed [DataW-1:0] eref_q   [NumAxes];
  logic signed [DataW-1:0] tmp_q    [NumAxes];
  logic signed [DataW-1:0] acc_q    [NumAxes];
  logic signed [DataW-1:0] err_q    [NumAxes];
  logic signed [DataW-1:0] derr_q   [NumAxes];
  logic signed [SumW-1:0]  sum_q    [NumAxes];
  logic signed [DataW-1:0] res_q    [NumAxes];
  logic signed [ProdW-1:0] prod_q   [NumAxes];
  logic signed [ProdW-1:0] prod_d   [NumAxes];
  logic signed [DataW-1:0] mul_a    [NumAxes];
  logic signed [DataW-1:0] fxp      [NumAxes];
  logic        [GainW-1:0] mul_b;

  always_comb begin
    in_cmd[0]  = cmd_x_i;
    in_cmd[1]  = cmd_y_i;
    in_mpos[0] = meas_pos_x_i;
    in_mpos[1] = meas_pos_y_i;
    in_mvel[0] = meas_vel_x_i;
    in_mvel[1] = meas_vel_y_i;
  end

  // shared gain operand
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_EREF_RKP: mul_b = ref_kp_i;
      MUL_VEL_RKD:  mul_b = ref_kd_i;
      MUL_ERR_KI:   mul_b = pid_ki_i;
      MUL_ERR_KP:   mul_b = pid_kp_i;
      MUL_DERR_KD:  mul_b = pid_kd_i;
      default:      mul_b = {{(GainW-TsW){1'b0}}, time_step_i};
    endcase
  end

  // one multiplier per axis lane
  always_comb begin
    for (int l = 0; l < NumAxes; l++) begin
      unique case (cmd_i.mul_sel)
        MUL_EREF_RKP: mul_a[l] = eref_q[l];
        MUL_VEL_RKD:  mul_a[l] = vel_q[l];
        MUL_ACC_TS:   mul_a[l] = acc_q[l];
        MUL_VEL_TS:   mul_a[l] = vel_q[l];
        MUL_ERR_KI:   mul_a[l] = err_q[l];
        MUL_ERR_KP:   mul_a[l] = err_q[l];
        MUL_TMP_TS:   mul_a[l] = tmp_q[l];
        MUL_DERR_KD:  mul_a[l] = derr_q[l];
        default:      mul_a[l] = eref_q[l];
      endcase
      prod_d[l] = mul_a[l] * $signed({1'b0, mul_b});
      fxp[l]    = fx_round(prod_q[l]);
    end
  end

  // axis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NumAxes; l++) begin
        pos_q[l]   <= '0;
        vel_q[l]   <= '0;
        integ_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < NumAxes; l++) begin
        if (cmd_i.upd_vel) begin
          vel_q[l] <= sat_data(ext_sum(vel_q[l]) + ext_sum(fxp[l]));
        end
        if (cmd_i.upd_pos) begin
          pos_q[l] <= sat_data(ext_sum(pos_q[l]) + ext_sum(fxp[l]));
        end
        if (cmd_i.upd_integ) begin
          integ_q[l] <= sat_data(ext_sum(integ_q[l]) + ext_sum(fxp[l]));
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumAxes; l++) begin
      if (cmd_i.ld_in) begin
        cmd_q[l]  <= in_cmd[l];
        mpos_q[l] <= in_mpos[l];
        mvel_q[l] <= in_mvel[l];
      end
      if (cmd_i.ld_eref) begin
        eref_q[l] <= sat_data(ext_sum(cmd_q[l]) - ext_sum(pos_q[l]));
      end
      if (cmd_i.mul_en) begin
        prod_q[l] <= prod_d[l];
      end
      if (cmd_i.ld_tmp) begin
        tmp_q[l] <= fxp[l];
      end
      if (cmd_i.ld_acc) begin
        acc_q[l] <= sat_data(ext_sum(tmp_q[l]) - ext_sum(fxp[l]));
      end
      if (cmd_i.ld_err) begin
        err_q[l]  <= sat_data(ext_sum(pos_q[l]) - ext_sum(mpos_q[l]));
        derr_q[l] <= sat_data(ext_sum(vel_q[l]) - ext_sum(mvel_q[l]));
      end
      if (cmd_i.ld_sum) begin
        sum_q[l] <= ext_sum(acc_q[l]) + ext_sum(fxp[l]);
      end
      if (cmd_i.ld_res) begin
        res_q[l] <= sat_data(sum_q[l] + ext_sum(integ_q[l]) + ext_sum(fxp[l]));
      end
    end
  end

  assign acc_out_x_o = res_q[0];
  assign acc_out_y_o = res_q[1];

endmodule

// File: hw/rtl/xypid_ctrl.sv
`include "xy_position_pid_with_reference_model_top_defines.svh"

module xypid_ctrl import xypid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output xypid_cmd_t cmd_o
);

  xypid_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = ST_EREF;
        end
      end
      ST_EREF: begin
        cmd_o.ld_eref = 1'b1;
        state_d       = ST_M1;
      end
      ST_M1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_EREF_RKP;
        state_d       = ST_M2;
      end
      ST_M2: begin
        cmd_o.ld_tmp  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VEL_RKD;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.ld_acc = 1'b1;
        state_d      = ST_M3;
      end
      ST_M3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ACC_TS;
        state_d       = ST_VEL;
      end
      ST_VEL: begin
        cmd_o.upd_vel = 1'b1;
        state_d       = ST_M4;
      end
      ST_M4: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VEL_TS;
        state_d       = ST_POS;
      end
      ST_POS: begin
        cmd_o.upd_pos = 1'b1;
        state_d       = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.ld_err = 1'b1;
        state_d      = ST_M5;
      end
      ST_M5: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ERR_KI;
        state_d       = ST_M6;
      end
      ST_M6: begin
        cmd_o.ld_tmp  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ERR_KP;
        state_d       = ST_M7;
      end
      ST_M7: begin
        cmd_o.ld_sum  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TMP_TS;
        state_d       = ST_INT;
      end
      ST_INT: begin
        cmd_o.upd_integ = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_DERR_KD;
        state_d         = ST_FIN;
      end
      ST_FIN: begin
        // wait here until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_res = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `XYPID_ASSERT(a_res_slot_free, clk_i, rst_ni, cmd_o.ld_res |-> (!out_valid_q || out_ready_i))
  `XYPID_ASSERT(a_accept_starts, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> state_q == ST_EREF)
  `XYPID_ASSERT(a_valid_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
  `XYPID_NEVER(a_no_accept_on_res, clk_i, rst_ni, in_ready_o && cmd_o.ld_res)

endmodule

// File: hw/rtl/xy_position_pid_with_reference_model_top.sv
// xy position controller: second-order reference trajectory plus pid with feedforward
// input channel (in_valid_i / in_ready_o): one request per control tick carrying
//   the x/y command and the measured x/y position and velocity, signed q16.16
// output channel (out_valid_o / out_ready_i): one request per tick with the
//   desired x/y acceleration, saturated to 32 bits
// config channel (cfg_valid_i / cfg_ready_o): index 0..5 selects ref_kp, ref_kd,
//   pid_kp, pid_ki, pid_kd, time_step; data is masked to the register width,
//   other indexes are dropped; always ready, write only while idle
// datapath: both axes run in parallel lanes, one 32x25 multiplier each, stepped by the
//   controller through 14 steps from input accept to out_valid_o
// ticks: a new tick is accepted only while idle, once the previous tick has run
//   through the whole step sequence around the lane multipliers
// stall: a finished result sits in the output register; a new tick is accepted
//   meanwhile, and its final step waits until the previous result is taken
// reset: reference position, velocity and integrators clear to zero, gains go
//   to their defaults, no result pending
module xy_position_pid_with_reference_model_top import xypid_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic        [CfgIdxW-1:0]  cfg_index_i,
  input  logic        [CfgDataW-1:0] cfg_data_i,
  // tick input
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [DataW-1:0]    cmd_x_i,
  input  logic signed [DataW-1:0]    cmd_y_i,
  input  logic signed [DataW-1:0]    meas_pos_x_i,
  input  logic signed [DataW-1:0]    meas_pos_y_i,
  input  logic signed [DataW-1:0]    meas_vel_x_i,
  input  logic signed [DataW-1:0]    meas_vel_y_i,
  // acceleration output
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [DataW-1:0]    acc_out_x_o,
  output logic signed [DataW-1:0]    acc_out_y_o
);

  logic [GainW-1:0] ref_kp_q, ref_kd_q, pid_kp_q, pid_ki_q, pid_kd_q;
  logic [TsW-1:0]   time_step_q;
  xypid_cmd_t       cmd;

  assign cfg_ready_o = 1'b1;

  // gain and period registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_kp_q    <= RefKpRst;
      ref_kd_q    <= RefKdRst;
      pid_kp_q    <= PidKpRst;
      pid_ki_q    <= PidKiRst;
      pid_kd_q    <= PidKdRst;
      time_step_q <= TimeStepRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRefKp:    ref_kp_q    <= cfg_data_i[GainW-1:0];
        RegRefKd:    ref_kd_q    <= cfg_data_i[GainW-1:0];
        RegPidKp:    pid_kp_q    <= cfg_data_i[GainW-1:0];
        RegPidKi:    pid_ki_q    <= cfg_data_i[GainW-1:0];
        RegPidKd:    pid_kd_q    <= cfg_data_i[GainW-1:0];
        RegTimeStep: time_step_q <= cfg_data_i[TsW-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // step sequencer and handshakes
  xypid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // two axis lanes with state, temporaries and result register
  xypid_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .ref_kp_i     (ref_kp_q),
    .ref_kd_i     (ref_kd_q),
    .pid_kp_i     (pid_kp_q),
    .pid_ki_i     (pid_ki_q),
    .pid_kd_i     (pid_kd_q),
    .time_step_i  (time_step_q),
    .cmd_x_i      (cmd_x_i),
    .cmd_y_i      (cmd_y_i),
    .meas_pos_x_i (meas_pos_x_i),
    .meas_pos_y_i (meas_pos_y_i),
    .meas_vel_x_i (meas_vel_x_i),
    .meas_vel_y_i (meas_vel_y_i),
    .acc_out_x_o  (acc_out_x_o),
    .acc_out_y_o  (acc_out_y_o)
  );

endmodule
